// ----- rtl/core/c8core_pkg.sv -----
// c8core_pkg: shared types and constants for the chip8 instruction core
// no dependencies
`timescale 1ns / 1ps

package c8core_pkg;

   // item actions
   localparam logic [1:0] ACT_WRITE = 2'd0;
   localparam logic [1:0] ACT_EXEC  = 2'd1;
   localparam logic [1:0] ACT_READ  = 2'd2;

   // fault codes
   localparam logic [1:0] FAULT_NONE      = 2'd0;
   localparam logic [1:0] FAULT_OPCODE    = 2'd1;
   localparam logic [1:0] FAULT_UNDERFLOW = 2'd2;
   localparam logic [1:0] FAULT_OVERFLOW  = 2'd3;

   localparam logic [15:0] OP_CLS     = 16'h00E0;
   localparam logic [15:0] OP_RET     = 16'h00EE;
   localparam logic [15:0] FONT_BASE  = 16'h0050;
   localparam logic [11:0] PC_START   = 12'h200;
   localparam logic [7:0]  PIXEL_LEFT = 8'h80;

   typedef enum logic [4:0] {
      ST_CLEAR, ST_IDLE, ST_FETCH0, ST_FETCH1, ST_FETCH2, ST_EXEC,
      ST_CLS, ST_DRAW_RD, ST_DRAW_LEFT, ST_DRAW_RIGHT, ST_DRAW_NEXT,
      ST_BCD, ST_BCD_WR, ST_STORE, ST_LOAD_RD, ST_LOAD_WR, ST_FRD, ST_DONE
   } state_type;

endpackage

// ----- rtl/core/c8core_mem.sv -----
// c8core_mem: single port synchronous byte memory with a registered read
// depends on nothing
`timescale 1ns / 1ps

module c8core_mem #(
   parameter int DEPTH = 4096,
   parameter int AW    = 12
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] addr,
   input  logic [7:0]    wr_data,
   output logic [7:0]    rd_data
);

   logic [7:0] mem [DEPTH];

   // write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end

endmodule

// ----- rtl/core/chip8_instruction_core.sv -----
// chip8_instruction_core: top level, sequencer and register file
// depends on c8core_pkg and c8core_mem
//
//  channel | ports                              | direction
//  req     | action address write_data random   | in
//  rsp     | program_counter opcode read_byte.. | out
//
// one item at a time: a new request beat is taken only in the idle state.
// after reset both memories are swept to zero, one address a cycle; no item is
// taken meanwhile. the result beat holds until taken.
`timescale 1ns / 1ps

module chip8_instruction_core
   import c8core_pkg::*;
#(
   parameter int MEM_BYTES     = 4096,
   parameter int SCREEN_WIDTH  = 64,
   parameter int SCREEN_HEIGHT = 32,
   parameter int STACK_DEPTH   = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_action,
   input  logic [11:0] req_address,
   input  logic [7:0]  req_write_data,
   input  logic [7:0]  req_random_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [11:0] rsp_program_counter,
   output logic [15:0] rsp_opcode,
   output logic [7:0]  rsp_read_byte,
   output logic        rsp_display_changed,
   output logic [1:0]  rsp_fault
);

   localparam int MAW         = $clog2(MEM_BYTES);
   localparam int ROW_BYTES   = SCREEN_WIDTH / 8;
   localparam int FRAME_BYTES = ROW_BYTES * SCREEN_HEIGHT;
   localparam int FAW         = $clog2(FRAME_BYTES);
   localparam int XW          = $clog2(SCREEN_WIDTH);
   localparam int YW          = $clog2(SCREEN_HEIGHT);
   localparam int SPW         = $clog2(STACK_DEPTH + 1);
   localparam int SAW         = $clog2(STACK_DEPTH);
   localparam int CW          = (MAW > FAW) ? MAW : FAW;

   state_type state_ff, state_in;

   // architectural registers
   logic [7:0]     v_ff [16];
   logic [7:0]     v_in [16];
   logic [15:0]    i_ff, i_in;
   logic [11:0]    pc_ff, pc_in;
   logic [SPW-1:0] sp_ff, sp_in;
   logic [11:0]    stack_ff [STACK_DEPTH];
   logic           push;
   logic [7:0]     delay_ff, delay_in, sound_ff, sound_in;

   // item registers
   logic [1:0]  act_ff, act_in;
   logic [11:0] addr_ff, addr_in;
   logic [7:0]  wdata_ff, wdata_in, rnd_ff, rnd_in;
   logic [15:0] op_ff, op_in;
   logic [7:0]  rbyte_ff, rbyte_in;
   logic        chg_ff, chg_in, hit_ff, hit_in;
   logic [1:0]  fault_ff, fault_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [4:0]  row_ff, row_in;
   logic [7:0]  bits_ff, bits_in;
   logic [7:0]  vx_ff, vx_in;

   // memory ports
   logic           m_we, f_we;
   logic [MAW-1:0] m_addr;
   logic [FAW-1:0] f_addr;
   logic [7:0]     m_wd, f_wd, m_rd, f_rd;

   c8core_mem #(.DEPTH(MEM_BYTES), .AW(MAW)) u_main (
      .clock(clock), .wr_en(m_we), .addr(m_addr), .wr_data(m_wd), .rd_data(m_rd));
   c8core_mem #(.DEPTH(FRAME_BYTES), .AW(FAW)) u_frame (
      .clock(clock), .wr_en(f_we), .addr(f_addr), .wr_data(f_wd), .rd_data(f_rd));

   // opcode fields
   logic [3:0]  xi, yi, ni;
   logic [7:0]  nn, vx, vy;
   logic [11:0] nnn;
   assign xi  = op_ff[11:8];
   assign yi  = op_ff[7:4];
   assign ni  = op_ff[3:0];
   assign nn  = op_ff[7:0];
   assign nnn = op_ff[11:0];
   assign vx  = v_ff[xi];
   assign vy  = v_ff[yi];

   // draw geometry
   logic [XW-1:0] x0;
   logic [YW-1:0] y0;
   logic [YW:0]   py;
   logic [15:0]   sprite_word, cur_word;
   logic [15:0]   sprite_shift;
   logic [FAW-1:0] row_base;
   logic [XW-4:0] col;
   assign x0 = vx_ff[XW-1:0];
   assign y0 = vy[YW-1:0];
   assign py = {1'b0, y0} + (YW+1)'(row_ff);
   assign col = x0[XW-1:3];
   assign row_base = FAW'(py[YW-1:0]) * FAW'(ROW_BYTES);
   assign sprite_shift = {bits_ff, 8'h00} >> x0[2:0];
   assign sprite_word = sprite_shift;

   // bcd digits
   logic [7:0] bcd_h, bcd_t, bcd_o, rem100;
   always_comb begin
      bcd_h  = (vx_ff >= 8'd200) ? 8'd2 : (vx_ff >= 8'd100) ? 8'd1 : 8'd0;
      rem100 = vx_ff - 8'(bcd_h * 8'd100);
      bcd_t  = 8'((16'(rem100) * 16'd205) >> 11);
      bcd_o  = rem100 - 8'(bcd_t * 8'd10);
   end

   logic [MAW-1:0] i_plus;
   assign i_plus = MAW'(i_ff) + MAW'(cnt_ff);

   // state register and datapath registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         for (int k = 0; k < 16; k++) v_ff[k] <= 8'd0;
         i_ff     <= 16'd0;
         pc_ff    <= PC_START;
         sp_ff    <= '0;
         delay_ff <= 8'd0;
         sound_ff <= 8'd0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         for (int k = 0; k < 16; k++) v_ff[k] <= v_in[k];
         i_ff     <= i_in;
         pc_ff    <= pc_in;
         sp_ff    <= sp_in;
         delay_ff <= delay_in;
         sound_ff <= sound_in;
         cnt_ff   <= cnt_in;
      end
      act_ff   <= act_in;
      addr_ff  <= addr_in;
      wdata_ff <= wdata_in;
      rnd_ff   <= rnd_in;
      op_ff    <= op_in;
      rbyte_ff <= rbyte_in;
      chg_ff   <= chg_in;
      hit_ff   <= hit_in;
      fault_ff <= fault_in;
      row_ff   <= row_in;
      bits_ff  <= bits_in;
      vx_ff    <= vx_in;
      if (push) begin
         stack_ff[sp_ff[SAW-1:0]] <= pc_ff;
      end
   end

   // next state and outputs
   always_comb begin
      state_in = state_ff;
      for (int k = 0; k < 16; k++) v_in[k] = v_ff[k];
      i_in = i_ff;  pc_in = pc_ff;  sp_in = sp_ff;
      delay_in = delay_ff;  sound_in = sound_ff;
      act_in = act_ff;  addr_in = addr_ff;  wdata_in = wdata_ff;  rnd_in = rnd_ff;
      op_in = op_ff;  rbyte_in = rbyte_ff;  chg_in = chg_ff;  hit_in = hit_ff;
      fault_in = fault_ff;  cnt_in = cnt_ff;  row_in = row_ff;  bits_in = bits_ff;
      vx_in = vx_ff;
      push = 1'b0;
      m_we = 1'b0;  m_addr = '0;  m_wd = 8'd0;
      f_we = 1'b0;  f_addr = '0;  f_wd = 8'd0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      cur_word = 16'd0;

      case (state_ff)
         // sweep both memories to zero after reset
         ST_CLEAR: begin
            m_we = 1'b1;  m_addr = cnt_ff[MAW-1:0];
            f_we = (CW'(cnt_ff) < CW'(FRAME_BYTES));  f_addr = cnt_ff[FAW-1:0];
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CW'(MEM_BYTES - 1)) begin
               cnt_in = '0;
               state_in = ST_IDLE;
            end
         end
         // take a request beat
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               act_in = req_action;  addr_in = req_address;
               wdata_in = req_write_data;  rnd_in = req_random_byte;
               op_in = 16'd0;  rbyte_in = 8'd0;  chg_in = 1'b0;
               fault_in = FAULT_NONE;
               state_in = ST_FETCH0;
            end
         end
         ST_FETCH0: begin
            case (act_ff)
               ACT_WRITE: begin
                  m_we = 1'b1;  m_addr = MAW'(addr_ff);  m_wd = wdata_ff;
                  state_in = ST_DONE;
               end
               ACT_EXEC: begin
                  m_addr = MAW'(pc_ff);
                  state_in = ST_FETCH1;
               end
               ACT_READ: begin
                  f_addr = FAW'(addr_ff);
                  state_in = ST_FRD;
               end
               default: state_in = ST_DONE;
            endcase
         end
         ST_FRD: begin
            if (32'(addr_ff) < FRAME_BYTES) rbyte_in = f_rd;
            state_in = ST_DONE;
         end
         ST_FETCH1: begin
            op_in[15:8] = m_rd;
            m_addr = MAW'(pc_ff) + MAW'(1);
            state_in = ST_FETCH2;
         end
         ST_FETCH2: begin
            op_in[7:0] = m_rd;
            pc_in = pc_ff + 12'd2;
            state_in = ST_EXEC;
         end
         // decode and execute
         ST_EXEC: begin
            state_in = ST_DONE;
            vx_in = vx;
            case (op_ff[15:12])
               4'h0: begin
                  if (op_ff == OP_CLS) begin
                     cnt_in = '0;  f_addr = '0;
                     state_in = ST_CLS;
                  end else if (op_ff == OP_RET) begin
                     if (sp_ff == '0 || 32'(sp_ff) > STACK_DEPTH) begin
                        fault_in = FAULT_UNDERFLOW;
                     end else begin
                        sp_in = sp_ff - 1'b1;
                        pc_in = stack_ff[sp_in[SAW-1:0]];
                     end
                  end else begin
                     fault_in = FAULT_OPCODE;
                  end
               end
               4'h1: pc_in = nnn;
               4'h2: begin
                  if (32'(sp_ff) >= STACK_DEPTH) begin
                     fault_in = FAULT_OVERFLOW;
                  end else begin
                     push = 1'b1;  sp_in = sp_ff + 1'b1;  pc_in = nnn;
                  end
               end
               4'h3: if (vx == nn) pc_in = pc_ff + 12'd2;
               4'h4: if (vx != nn) pc_in = pc_ff + 12'd2;
               4'h5: if (vx == vy) pc_in = pc_ff + 12'd2;
               4'h6: v_in[xi] = nn;
               4'h7: v_in[xi] = vx + nn;
               4'h8: begin
                  case (ni)
                     4'h0: v_in[xi] = vy;
                     4'h1: v_in[xi] = vx | vy;
                     4'h2: v_in[xi] = vx & vy;
                     4'h3: v_in[xi] = vx ^ vy;
                     4'h4: begin
                        v_in[xi] = vx + vy;
                        v_in[15] = 8'({8'd0, vx} + {8'd0, vy} > 16'd255);
                     end
                     4'h5: begin v_in[xi] = vx - vy; v_in[15] = 8'(vx > vy); end
                     4'h6: begin v_in[xi] = vx >> 1; v_in[15] = 8'(vx[0]); end
                     4'h7: begin v_in[xi] = vy - vx; v_in[15] = 8'(vy > vx); end
                     4'hE: begin v_in[xi] = vx << 1; v_in[15] = 8'(vx[7]); end
                     default: fault_in = FAULT_OPCODE;
                  endcase
               end
               4'h9: if (vx != vy) pc_in = pc_ff + 12'd2;
               4'hA: i_in = {4'd0, nnn};
               4'hB: pc_in = 12'(v_ff[0]) + nnn;
               4'hC: v_in[xi] = rnd_ff & nn;
               4'hD: begin
                  // vf keeps its value until the collision flag lands, so vy stays valid
                  hit_in = 1'b0;  row_in = 5'd0;
                  state_in = ST_DRAW_NEXT;
               end
               4'hE: pc_in = pc_ff + 12'd2;
               default: begin
                  cnt_in = '0;
                  case (nn)
                     8'h07: v_in[xi] = delay_ff;
                     8'h0A: ;
                     8'h15: delay_in = vx;
                     8'h18: sound_in = vx;
                     8'h1E: i_in = i_ff + 16'(vx);
                     8'h29: i_in = FONT_BASE + 16'(vx) * 16'd5;
                     8'h33: state_in = ST_BCD;
                     8'h55: state_in = ST_STORE;
                     8'h65: state_in = ST_LOAD_RD;
                     default: fault_in = FAULT_OPCODE;
                  endcase
               end
            endcase
         end
         // clear sweep: read then zero each frame byte
         ST_CLS: begin
            f_addr = cnt_ff[FAW-1:0];
            f_we = 1'b1;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff != '0 && f_rd != 8'd0) chg_in = 1'b1;
            if (cnt_ff == CW'(FRAME_BYTES)) begin
               f_we = 1'b0;
               state_in = ST_DONE;
            end
         end
         // draw: fetch next sprite row, or set vf from the hit flag once the rows run out or leave the screen
         ST_DRAW_NEXT: begin
            if (5'(row_ff) >= 5'(ni) || 32'(py) >= SCREEN_HEIGHT) begin
               v_in[15] = {7'd0, hit_ff};
               state_in = ST_DONE;
            end else begin
               m_addr = MAW'(i_ff) + MAW'(row_ff);
               state_in = ST_DRAW_RD;
            end
         end
         ST_DRAW_RD: begin
            bits_in = m_rd;
            state_in = ST_DRAW_LEFT;
            f_addr = row_base + FAW'(col);
         end
         // left byte of the row
         ST_DRAW_LEFT: begin
            cur_word = sprite_word;
            f_addr = row_base + FAW'(col);
            f_we = 1'b1;
            f_wd = f_rd ^ cur_word[15:8];
            if ((f_rd & cur_word[15:8]) != 8'd0) hit_in = 1'b1;
            if (cur_word[15:8] != 8'd0) chg_in = 1'b1;
            if (32'(col) + 1 < ROW_BYTES && cur_word[7:0] != 8'd0) begin
               state_in = ST_DRAW_RIGHT;
            end else begin
               row_in = row_ff + 5'd1;
               state_in = ST_DRAW_NEXT;
            end
         end
         // right byte: issue read, then modify
         ST_DRAW_RIGHT: begin
            f_addr = row_base + FAW'(col) + FAW'(1);
            if (cnt_ff[0] == 1'b0) begin
               cnt_in[0] = 1'b1;
            end else begin
               cur_word = sprite_word;
               cnt_in[0] = 1'b0;
               f_we = 1'b1;
               f_wd = f_rd ^ cur_word[7:0];
               if ((f_rd & cur_word[7:0]) != 8'd0) hit_in = 1'b1;
               chg_in = 1'b1;
               row_in = row_ff + 5'd1;
               state_in = ST_DRAW_NEXT;
            end
         end
         // bcd digits, one byte a cycle
         ST_BCD: begin
            m_we = 1'b1;
            m_addr = i_plus;
            m_wd = (cnt_ff == '0) ? bcd_h : (cnt_ff == CW'(1)) ? bcd_t : bcd_o;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CW'(2)) state_in = ST_DONE;
         end
         ST_STORE: begin
            m_we = 1'b1;
            m_addr = i_plus;
            m_wd = v_ff[cnt_ff[3:0]];
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff[3:0] == xi) state_in = ST_DONE;
         end
         ST_LOAD_RD: begin
            m_addr = i_plus;
            state_in = ST_LOAD_WR;
         end
         ST_LOAD_WR: begin
            v_in[cnt_ff[3:0]] = m_rd;
            cnt_in = cnt_ff + 1'b1;
            state_in = (cnt_ff[3:0] == xi) ? ST_DONE : ST_LOAD_RD;
         end
         // hold the result beat
         ST_DONE: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               cnt_in = '0;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_program_counter = pc_ff;
   assign rsp_opcode          = op_ff;
   assign rsp_read_byte       = rbyte_ff;
   assign rsp_display_changed = chg_ff;
   assign rsp_fault           = fault_ff;

endmodule

// ----- tb/tb_top.sv -----
// tb_top: self-checking testbench for chip8_instruction_core
// depends on c8core_pkg and the core rtl; drives load, step and read beats and
// compares every result beat with a directed expectation or a behavioral model of the core kept here
`timescale 1ns / 1ps

module tb_top;
   import c8core_pkg::*;

   localparam logic [1:0] ACT_NOP   = 2'd3;
   localparam int         CYCLE_CAP = 3000000;
   localparam int         RAND_ITEMS = 970;

   typedef struct packed {
      logic [1:0]  action;
      logic [11:0] address;
      logic [7:0]  wdata;
      logic [7:0]  rnd;
   } beat_in_type;

   typedef struct packed {
      logic [11:0] pc;
      logic [15:0] op;
      logic [7:0]  rbyte;
      logic        changed;
      logic [1:0]  flt;
   } beat_out_type;

   typedef struct packed {
      beat_in_type  item;
      logic         typed;
      beat_out_type want;
   } dir_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_action = ACT_WRITE;
   logic [11:0] req_address = '0;
   logic [7:0]  req_write_data = '0;
   logic [7:0]  req_random_byte = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [11:0] rsp_program_counter;
   logic [15:0] rsp_opcode;
   logic [7:0]  rsp_read_byte;
   logic        rsp_display_changed;
   logic [1:0]  rsp_fault;

   // model state of the core
   logic [7:0]  mem_img [4096];
   logic [7:0]  vreg [16];
   logic [15:0] index_reg;
   logic [11:0] pc_reg;
   int          sp_reg;
   logic [11:0] ret_stack [16];
   logic [7:0]  frame_img [256];
   logic [7:0]  delay_reg;
   logic [7:0]  sound_reg;

   beat_out_type pending_rsp [$];
   int          err_count = 0;
   int          accepted_in = 0;
   int          cycles = 0;
   bit          burst_mode = 1'b0;
   logic        rx_hold = 1'b0;

   chip8_instruction_core DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_action(req_action), .req_address(req_address),
      .req_write_data(req_write_data), .req_random_byte(req_random_byte),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_program_counter(rsp_program_counter), .rsp_opcode(rsp_opcode),
      .rsp_read_byte(rsp_read_byte), .rsp_display_changed(rsp_display_changed),
      .rsp_fault(rsp_fault)
   );

   // 2 ns clock
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_CAP) begin
         $display("chip8_instruction_core regression: fail");
         $finish;
      end
   end

   // model: apply one item to the state, return the result beat
   function automatic beat_out_type run_item(beat_in_type it);
      beat_out_type r;
      logic [15:0] op;
      logic [3:0]  x, y, n;
      logic [7:0]  nn, vx, vy, res, flag, bits;
      logic [11:0] nnn;
      int          x0, y0, py, px, fi;
      logic        hit;
      r = '0;
      case (it.action)
         ACT_WRITE: mem_img[it.address] = it.wdata;
         ACT_READ: if (it.address < 256) r.rbyte = frame_img[it.address];
         ACT_EXEC: begin
            op = {mem_img[pc_reg], mem_img[pc_reg + 12'd1]};
            pc_reg = pc_reg + 12'd2;
            x = op[11:8]; y = op[7:4]; n = op[3:0]; nn = op[7:0]; nnn = op[11:0];
            r.op = op;
            case (op[15:12])
               4'h0: begin
                  if (op == OP_CLS) begin
                     for (int i = 0; i < 256; i++) begin
                        if (frame_img[i] != 0) r.changed = 1'b1;
                        frame_img[i] = '0;
                     end
                  end else if (op == OP_RET) begin
                     if (sp_reg == 0) r.flt = FAULT_UNDERFLOW;
                     else begin
                        sp_reg--;
                        pc_reg = ret_stack[sp_reg];
                     end
                  end else r.flt = FAULT_OPCODE;
               end
               4'h1: pc_reg = nnn;
               4'h2: begin
                  if (sp_reg >= 16) r.flt = FAULT_OVERFLOW;
                  else begin
                     ret_stack[sp_reg] = pc_reg;
                     sp_reg++;
                     pc_reg = nnn;
                  end
               end
               4'h3: if (vreg[x] == nn) pc_reg = pc_reg + 12'd2;
               4'h4: if (vreg[x] != nn) pc_reg = pc_reg + 12'd2;
               4'h5: if (vreg[x] == vreg[y]) pc_reg = pc_reg + 12'd2;
               4'h6: vreg[x] = nn;
               4'h7: vreg[x] = vreg[x] + nn;
               4'h8: begin
                  vx = vreg[x]; vy = vreg[y];
                  case (n)
                     4'h0: vreg[x] = vy;
                     4'h1: vreg[x] = vx | vy;
                     4'h2: vreg[x] = vx & vy;
                     4'h3: vreg[x] = vx ^ vy;
                     4'h4, 4'h5, 4'h6, 4'h7, 4'hE: begin
                        case (n)
                           4'h4: begin res = vx + vy; flag = ({1'b0, vx} + vy) > 9'hFF; end
                           4'h5: begin res = vx - vy; flag = vx > vy; end
                           4'h6: begin res = vx >> 1; flag = vx[0]; end
                           4'h7: begin res = vy - vx; flag = vy > vx; end
                           default: begin res = vx << 1; flag = vx[7]; end
                        endcase
                        // flag lands after the result
                        vreg[x] = res;
                        vreg[15] = flag;
                     end
                     default: r.flt = FAULT_OPCODE;
                  endcase
               end
               4'h9: if (vreg[x] != vreg[y]) pc_reg = pc_reg + 12'd2;
               4'hA: index_reg = {4'h0, nnn};
               4'hB: pc_reg = vreg[0] + nnn;
               4'hC: vreg[x] = it.rnd & nn;
               4'hD: begin
                  // xor sprite, clipped at right and bottom edges
                  x0 = vreg[x] % 64; y0 = vreg[y] % 32; hit = 1'b0;
                  for (int rr = 0; rr < n; rr++) begin
                     py = y0 + rr;
                     if (py >= 32) break;
                     bits = mem_img[(index_reg + rr) & 16'hFFF];
                     for (int c = 0; c < 8; c++) begin
                        px = x0 + c;
                        if (px >= 64) break;
                        if (bits[7 - c]) begin
                           fi = py * 8 + px / 8;
                           if (frame_img[fi] & (PIXEL_LEFT >> (px % 8))) hit = 1'b1;
                           frame_img[fi] = frame_img[fi] ^ (PIXEL_LEFT >> (px % 8));
                           r.changed = 1'b1;
                        end
                     end
                  end
                  vreg[15] = {7'd0, hit};
               end
               4'hE: pc_reg = pc_reg + 12'd2;
               default: begin
                  vx = vreg[x];
                  case (nn)
                     8'h07: vreg[x] = delay_reg;
                     8'h0A: ;
                     8'h15: delay_reg = vx;
                     8'h18: sound_reg = vx;
                     8'h1E: index_reg = index_reg + vx;
                     8'h29: index_reg = FONT_BASE + 16'd5 * vx;
                     8'h33: begin
                        mem_img[index_reg[11:0]] = vx / 100;
                        mem_img[(index_reg + 1) & 16'hFFF] = (vx / 10) % 10;
                        mem_img[(index_reg + 2) & 16'hFFF] = vx % 10;
                     end
                     8'h55: for (int k = 0; k <= x; k++)
                        mem_img[(index_reg + k) & 16'hFFF] = vreg[k];
                     8'h65: for (int k = 0; k <= x; k++)
                        vreg[k] = mem_img[(index_reg + k) & 16'hFFF];
                     default: r.flt = FAULT_OPCODE;
                  endcase
               end
            endcase
         end
         default: ;
      endcase
      r.pc = pc_reg;
      return r;
   endfunction

   // pick one instruction, weighted toward the families that reach deep state
   function automatic logic [15:0] pick_opcode();
      int          sel;
      logic [3:0]  x, y;
      logic [7:0]  nn;
      logic [7:0]  fx_codes [9] = '{8'h07, 8'h0A, 8'h15, 8'h18, 8'h1E,
                                    8'h29, 8'h33, 8'h55, 8'h65};
      sel = $urandom_range(0, 99);
      x = 4'($urandom); y = 4'($urandom); nn = 8'($urandom);
      if (sel < 2) return OP_CLS;
      if (sel < 8) return OP_RET;
      if (sel < 14) return {4'h2, 12'($urandom)};
      if (sel < 18) return {4'h1, 12'($urandom)};
      if (sel < 21) return {4'hB, 12'($urandom)};
      if (sel < 27) return {4'h3, x, ($urandom_range(0, 1) ? vreg[x] : nn)};
      if (sel < 32) return {4'h4, x, ($urandom_range(0, 1) ? vreg[x] : nn)};
      if (sel < 37) return {4'h5, x, y, 4'($urandom)};
      if (sel < 41) return {4'h9, x, y, 4'($urandom)};
      if (sel < 51) return {4'h6, x, nn};
      if (sel < 57) return {4'h7, x, nn};
      if (sel < 71) return {4'h8, x, y, ($urandom_range(0, 4) == 0) ? 4'($urandom)
                                           : 4'($urandom_range(0, 8) == 8 ? 14 : $urandom_range(0, 7))};
      if (sel < 76) return {4'hA, 12'($urandom)};
      if (sel < 80) return {4'hC, x, nn};
      if (sel < 88) return {4'hD, x, y, 4'($urandom)};
      if (sel < 90) return {4'hE, x, nn};
      if (sel < 98) return {4'hF, x, ($urandom_range(0, 5) == 0) ? nn
                                      : fx_codes[$urandom_range(0, 8)]};
      return {4'h0, 12'($urandom)};
   endfunction

   // offer one beat and wait for it to be taken, then record its result
   task automatic send_beat(beat_in_type it, logic typed, beat_out_type want);
      int           gap;
      beat_out_type got;
      gap = burst_mode ? 0 : $urandom_range(0, 10);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_action <= it.action;
      req_address <= it.address;
      req_write_data <= it.wdata;
      req_random_byte <= it.rnd;
      do @(posedge clock); while (!req_ready);
      accepted_in++;
      got = run_item(it);
      pending_rsp.push_back(typed ? want : got);
      if (accepted_in % 64 == 0) burst_mode = ($urandom_range(0, 3) == 0);
   endtask

   // one instruction: load its two bytes at the model pc, then step
   task automatic send_instr(logic [15:0] op);
      beat_in_type it;
      it = '{ACT_WRITE, pc_reg, op[15:8], 8'($urandom)};
      send_beat(it, 1'b0, '0);
      it = '{ACT_WRITE, pc_reg + 12'd1, op[7:0], 8'($urandom)};
      send_beat(it, 1'b0, '0);
      it = '{ACT_EXEC, 12'($urandom), 8'($urandom), 8'($urandom)};
      send_beat(it, 1'b0, '0);
   endtask

   // result side: random ready gaps, long hold when asked
   initial begin : rx_side
      int           gap;
      beat_out_type want;
      @(negedge reset);
      forever begin
         gap = burst_mode ? 0 : $urandom_range(0, 10);
         if (gap != 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         while (rx_hold) begin
            rsp_ready <= 1'b0;
            @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         if (pending_rsp.size() == 0) begin
            $error("result beat with nothing expected");
            err_count++;
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_program_counter !== want.pc) begin
               $error("program_counter exp %h got %h", want.pc, rsp_program_counter);
               err_count++;
            end
            if (rsp_opcode !== want.op) begin
               $error("opcode exp %h got %h", want.op, rsp_opcode);
               err_count++;
            end
            if (rsp_read_byte !== want.rbyte) begin
               $error("read_byte exp %h got %h", want.rbyte, rsp_read_byte);
               err_count++;
            end
            if (rsp_display_changed !== want.changed) begin
               $error("display_changed exp %b got %b", want.changed, rsp_display_changed);
               err_count++;
            end
            if (rsp_fault !== want.flt) begin
               $error("fault exp %0d got %0d", want.flt, rsp_fault);
               err_count++;
            end
         end
      end
   end

   // long receiver hold so the core backs up into its input
   initial begin : rx_stall
      wait (accepted_in >= 300);
      @(posedge clock);
      rx_hold <= 1'b1;
      repeat (600) @(posedge clock);
      rx_hold <= 1'b0;
   end

   // main sequence
   initial begin : stim
      dir_row_type dir_tab [$];
      beat_in_type it;
      int          mark;
      for (int i = 0; i < 4096; i++) mem_img[i] = '0;
      for (int i = 0; i < 256; i++) frame_img[i] = '0;
      for (int i = 0; i < 16; i++) begin
         vreg[i] = '0;
         ret_stack[i] = '0;
      end
      index_reg = '0; pc_reg = PC_START; sp_reg = 0; delay_reg = '0; sound_reg = '0;

      // directed rows: reset view, extremes, faults, pc wrap
      dir_tab.push_back('{'{ACT_READ, 12'h000, 8'h00, 8'h00}, 1'b1,
                          '{12'h200, 16'h0, 8'h0, 1'b0, FAULT_NONE}});
      dir_tab.push_back('{'{ACT_READ, 12'hFFF, 8'hFF, 8'hFF}, 1'b1,
                          '{12'h200, 16'h0, 8'h0, 1'b0, FAULT_NONE}});
      dir_tab.push_back('{'{ACT_NOP, 12'hFFF, 8'hFF, 8'hFF}, 1'b1,
                          '{12'h200, 16'h0, 8'h0, 1'b0, FAULT_NONE}});
      dir_tab.push_back('{'{ACT_WRITE, 12'h200, 8'h00, 8'h00}, 1'b1,
                          '{12'h200, 16'h0, 8'h0, 1'b0, FAULT_NONE}});
      dir_tab.push_back('{'{ACT_WRITE, 12'h201, 8'hEE, 8'h00}, 1'b1,
                          '{12'h200, 16'h0, 8'h0, 1'b0, FAULT_NONE}});
      dir_tab.push_back('{'{ACT_EXEC, 12'h000, 8'h00, 8'h00}, 1'b1,
                          '{12'h202, OP_RET, 8'h0, 1'b0, FAULT_UNDERFLOW}});
      dir_tab.push_back('{'{ACT_WRITE, 12'h202, 8'h01, 8'h00}, 1'b0, '0});
      dir_tab.push_back('{'{ACT_WRITE, 12'h203, 8'h23, 8'h00}, 1'b0, '0});
      dir_tab.push_back('{'{ACT_EXEC, 12'h000, 8'h00, 8'h00}, 1'b1,
                          '{12'h204, 16'h0123, 8'h0, 1'b0, FAULT_OPCODE}});
      dir_tab.push_back('{'{ACT_WRITE, 12'h204, 8'h6F, 8'h00}, 1'b0, '0});
      dir_tab.push_back('{'{ACT_WRITE, 12'h205, 8'hFF, 8'h00}, 1'b0, '0});
      dir_tab.push_back('{'{ACT_EXEC, 12'h000, 8'h00, 8'hFF}, 1'b1,
                          '{12'h206, 16'h6FFF, 8'h0, 1'b0, FAULT_NONE}});
      dir_tab.push_back('{'{ACT_WRITE, 12'h206, 8'h8F, 8'h00}, 1'b0, '0});
      dir_tab.push_back('{'{ACT_WRITE, 12'h207, 8'hFE, 8'h00}, 1'b0, '0});
      dir_tab.push_back('{'{ACT_EXEC, 12'h000, 8'h00, 8'h00}, 1'b0, '0});
      dir_tab.push_back('{'{ACT_WRITE, 12'h208, 8'hF0, 8'h00}, 1'b0, '0});
      dir_tab.push_back('{'{ACT_WRITE, 12'h209, 8'h29, 8'h00}, 1'b0, '0});
      dir_tab.push_back('{'{ACT_EXEC, 12'h000, 8'h00, 8'h00}, 1'b1,
                          '{12'h20A, 16'hF029, 8'h0, 1'b0, FAULT_NONE}});
      dir_tab.push_back('{'{ACT_WRITE, 12'h20A, 8'hD0, 8'h00}, 1'b0, '0});
      dir_tab.push_back('{'{ACT_WRITE, 12'h20B, 8'h05, 8'h00}, 1'b0, '0});
      dir_tab.push_back('{'{ACT_EXEC, 12'h000, 8'h00, 8'h00}, 1'b1,
                          '{12'h20C, 16'hD005, 8'h0, 1'b0, FAULT_NONE}});
      dir_tab.push_back('{'{ACT_WRITE, 12'hFFF, 8'hFF, 8'h00}, 1'b0, '0});
      dir_tab.push_back('{'{ACT_WRITE, 12'h20C, 8'h1F, 8'h00}, 1'b0, '0});
      dir_tab.push_back('{'{ACT_WRITE, 12'h20D, 8'hFE, 8'h00}, 1'b0, '0});
      dir_tab.push_back('{'{ACT_EXEC, 12'h000, 8'h00, 8'h00}, 1'b1,
                          '{12'hFFE, 16'h1FFE, 8'h0, 1'b0, FAULT_NONE}});

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_tab[i]) send_beat(dir_tab[i].item, dir_tab[i].typed, dir_tab[i].want);

      // random programs with loose writes, reads and idle beats mixed in
      mark = accepted_in;
      while (accepted_in - mark < RAND_ITEMS) begin
         case ($urandom_range(0, 19))
            0: begin
               it = '{ACT_WRITE, 12'($urandom), 8'($urandom), 8'($urandom)};
               send_beat(it, 1'b0, '0);
            end
            1, 2: begin
               it = '{ACT_READ, ($urandom_range(0, 7) == 0) ? 12'($urandom)
                                 : 12'($urandom_range(0, 255)), 8'($urandom), 8'($urandom)};
               send_beat(it, 1'b0, '0);
            end
            3: begin
               it = '{ACT_NOP, 12'($urandom), 8'($urandom), 8'($urandom)};
               send_beat(it, 1'b0, '0);
            end
            default: send_instr(pick_opcode());
         endcase
         // one deep call chain past the stack top, then unwind past empty
         if (accepted_in - mark > 500 && accepted_in - mark < 505) begin
            repeat (18) send_instr({4'h2, 12'($urandom)});
            repeat (18) send_instr(OP_RET);
         end
      end
      req_valid <= 1'b0;

      wait (pending_rsp.size() == 0);
      repeat (40) @(posedge clock);
      if (err_count == 0)
         $display("chip8_instruction_core regression: pass");
      else
         $display("chip8_instruction_core regression: fail");
      $finish;
   end

endmodule

// ----- chip8_instruction_core.f -----
rtl/core/c8core_pkg.sv
rtl/core/c8core_mem.sv
rtl/core/chip8_instruction_core.sv
tb/tb_top.sv
